// ===== rtl/ps2_mouse_packet_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// ps2 mouse packet tracker assertion macros
// shared property forms for the tracker's concurrent checks
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PS2MPT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ps2mpt assertion failed");

// next-cycle implication, checked out of reset
`define PS2MPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ps2mpt assertion failed");

`endif

// ===== rtl/ps2mpt_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2mpt_pkg
// types, constants and helpers shared by the mouse packet tracker
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

	localparam int COORD_BITS = 12;
	localparam int DIM_BITS   = 13;
	localparam int CFG_BITS   = 13;
	localparam int EFF_BITS   = COORD_BITS + 1;
	localparam int CMP_BITS   = (EFF_BITS > DIM_BITS) ? EFF_BITS : DIM_BITS;
	localparam int SUM_BITS   = COORD_BITS + 2;
	localparam int WHEEL_BITS = 16;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	localparam logic [1:0] CFG_WHEEL_MODE  = 2'd0;
	localparam logic [1:0] CFG_DISP_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_DISP_HEIGHT = 2'd2;

	localparam logic REQ_BYTE     = 1'b0;
	localparam logic REQ_RECENTER = 1'b1;

	localparam int SYNC_BIT = 3;

	typedef struct packed {
		logic       req_type;
		logic       buffer_full;
		logic       from_aux;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic                wheel_mode;
		logic [DIM_BITS-1:0] disp_width;
		logic [DIM_BITS-1:0] disp_height;
	} cfg_t;

	typedef struct packed {
		logic                         packet_done;
		logic [COORD_BITS-1:0]        cursor_x;
		logic [COORD_BITS-1:0]        cursor_y;
		logic signed [WHEEL_BITS-1:0] wheel_pos;
		logic [2:0]                   buttons;
	} result_t;

	// zero acts as one, anything above the coordinate range acts as its full size
	function automatic logic [EFF_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] v);
		logic [EFF_BITS-1:0] lim;
		logic [EFF_BITS-1:0] r;
		lim = EFF_BITS'(1) << COORD_BITS;
		if (v == '0) begin
			r = EFF_BITS'(1);
		end else if (CMP_BITS'(v) > CMP_BITS'(lim)) begin
			r = lim;
		end else begin
			r = EFF_BITS'(v);
		end
		return r;
	endfunction

	function automatic logic [COORD_BITS-1:0] clamp_pos(input logic signed [SUM_BITS-1:0] p,
			input logic [EFF_BITS-1:0] dim);
		logic signed [SUM_BITS-1:0] dim_s;
		logic [COORD_BITS-1:0]      r;
		dim_s = $signed({1'b0, dim});
		if (p < 0) begin
			r = '0;
		end else if (p >= dim_s) begin
			r = COORD_BITS'(dim - EFF_BITS'(1));
		end else begin
			r = COORD_BITS'(p);
		end
		return r;
	endfunction

endpackage

// ===== rtl/ps2mpt_core.sv =====
// ----------------------------------------------------------------------------
// ps2mpt_core
// packet assembly, position and wheel state with their combinational update
// ----------------------------------------------------------------------------
module ps2mpt_core import ps2mpt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    fire,
	input  item_t   item,
	output result_t res
);

	logic [1:0]                   byte_count_q;
	logic [7:0]                   pkt_q [3];
	logic [COORD_BITS-1:0]        pos_x_q;
	logic [COORD_BITS-1:0]        pos_y_q;
	logic signed [WHEEL_BITS-1:0] pos_z_q;
	logic [2:0]                   buttons_q;

	logic [1:0]                   last;
	logic [1:0]                   cnt;
	logic [EFF_BITS-1:0]          dim_x;
	logic [EFF_BITS-1:0]          dim_y;
	logic [7:0]                   b2;
	logic signed [8:0]            dx;
	logic signed [8:0]            dy;
	logic signed [SUM_BITS-1:0]   sum_x;
	logic signed [SUM_BITS-1:0]   sum_y;
	logic signed [WHEEL_BITS:0]   sum_z;
	logic                         recenter;
	logic                         take;
	logic                         sync_bad;
	logic                         store;
	logic                         done;
	logic [1:0]                   byte_count_d;
	logic [COORD_BITS-1:0]        pos_x_d;
	logic [COORD_BITS-1:0]        pos_y_d;
	logic signed [WHEEL_BITS-1:0] pos_z_d;
	logic [2:0]                   buttons_d;

	always_comb begin
		last     = cfg.wheel_mode ? 2'd3 : 2'd2;
		// a full buffer left over from wheel mode restarts the packet
		cnt      = (byte_count_q > last) ? 2'd0 : byte_count_q;
		dim_x    = eff_dim(cfg.disp_width);
		dim_y    = eff_dim(cfg.disp_height);
		b2       = cfg.wheel_mode ? pkt_q[2] : item.data_byte;
		dx       = $signed({pkt_q[0][4], pkt_q[1]});
		dy       = $signed({pkt_q[0][5], b2});
		sum_x    = $signed({2'b00, pos_x_q}) + SUM_BITS'(dx);
		sum_y    = $signed({2'b00, pos_y_q}) - SUM_BITS'(dy);
		sum_z    = (WHEEL_BITS+1)'(pos_z_q) + (WHEEL_BITS+1)'($signed(item.data_byte));

		recenter = fire && (item.req_type == REQ_RECENTER);
		take     = fire && (item.req_type == REQ_BYTE) && item.buffer_full && item.from_aux;
		sync_bad = (cnt == 2'd0) && !item.data_byte[SYNC_BIT];
		store    = take && !sync_bad && (cnt < last);
		done     = take && !sync_bad && (cnt == last);

		byte_count_d = byte_count_q;
		pos_x_d      = pos_x_q;
		pos_y_d      = pos_y_q;
		pos_z_d      = pos_z_q;
		buttons_d    = buttons_q;

		if (recenter) begin
			byte_count_d = 2'd0;
			pos_x_d      = COORD_BITS'(dim_x >> 1);
			pos_y_d      = COORD_BITS'(dim_y >> 1);
			pos_z_d      = '0;
		end else if (take) begin
			if (store) begin
				byte_count_d = cnt + 2'd1;
			end else if (done) begin
				byte_count_d = 2'd0;
			end else begin
				byte_count_d = cnt;
			end
			if (done) begin
				buttons_d = pkt_q[0][2:0];
				pos_x_d   = clamp_pos(sum_x, dim_x);
				pos_y_d   = clamp_pos(sum_y, dim_y);
				if (cfg.wheel_mode) begin
					if (sum_z[WHEEL_BITS] != sum_z[WHEEL_BITS-1]) begin
						pos_z_d = sum_z[WHEEL_BITS] ? {1'b1, {(WHEEL_BITS-1){1'b0}}}
							: {1'b0, {(WHEEL_BITS-1){1'b1}}};
					end else begin
						pos_z_d = sum_z[WHEEL_BITS-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 2'd0;
			pos_x_q      <= COORD_BITS'(RESET_WIDTH / 2);
			pos_y_q      <= COORD_BITS'(RESET_HEIGHT / 2);
			pos_z_q      <= '0;
			buttons_q    <= '0;
		end else begin
			byte_count_q <= byte_count_d;
			pos_x_q      <= pos_x_d;
			pos_y_q      <= pos_y_d;
			pos_z_q      <= pos_z_d;
			buttons_q    <= buttons_d;
		end
	end

	// packet bytes, only read once written in the current packet
	always_ff @(posedge clk) begin
		if (store) begin
			pkt_q[cnt] <= item.data_byte;
		end
	end

	assign res.packet_done = done;
	assign res.cursor_x    = pos_x_d;
	assign res.cursor_y    = pos_y_d;
	assign res.wheel_pos   = pos_z_d;
	assign res.buttons     = buttons_d;

`include "ps2_mouse_packet_tracker_assert.svh"

	`PS2MPT_ASSERT_NEXT(a_done_restarts, done, byte_count_q == 2'd0)
	`PS2MPT_ASSERT_NEXT(a_recenter_clears, recenter, (pos_z_q == '0) && (byte_count_q == 2'd0))
	`PS2MPT_ASSERT_NEXT(a_idle_holds, !fire,
		$stable(pos_x_q) && $stable(pos_y_q) && $stable(pos_z_q) && $stable(byte_count_q))
	`PS2MPT_ASSERT_NOW(a_done_on_screen, done,
		({1'b0, pos_x_d} < dim_x) && ({1'b0, pos_y_d} < dim_y))

endmodule

// ===== rtl/ps2mpt_out_reg.sv =====
// ----------------------------------------------------------------------------
// ps2mpt_out_reg
// result register holding one transaction until the consumer takes it
// ----------------------------------------------------------------------------
module ps2mpt_out_reg import ps2mpt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	output logic    ready,
	output logic    valid,
	input  logic    stall,
	output result_t res_out
);

	logic    valid_q;
	result_t res_q;

	// free when empty or when the held transaction leaves this cycle
	assign ready = !valid_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign valid   = valid_q;
	assign res_out = res_q;

endmodule

// ===== rtl/ps2_mouse_packet_tracker.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// ps/2 mouse packet assembly with clamped cursor and saturating wheel tracking
// ----------------------------------------------------------------------------
// Each transaction produces exactly one result. The tracker takes one item per
// cycle while in_stall is low: an item is registered on input, its packet, cursor
// and wheel update is done combinationally against the state left by the
// previous item, and the result is registered on output, so a result passes the
// input register and then the result register, and is taken in a cycle when
// out_stall is low. The combinational state update loop sets that rate; while
// the result register is held by out_stall the input register fills and then
// in_stall rises. Configuration writes take effect on the next cycle.
module ps2_mouse_packet_tracker import ps2mpt_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [CFG_BITS-1:0]          cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic                         buffer_full,
	input  logic                         from_aux,
	input  logic [7:0]                   data_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         packet_done,
	output logic [COORD_BITS-1:0]        cursor_x,
	output logic [COORD_BITS-1:0]        cursor_y,
	output logic signed [WHEEL_BITS-1:0] wheel_pos,
	output logic                         btn_left,
	output logic                         btn_right,
	output logic                         btn_middle
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	logic    out_ready;
	logic    fire;
	logic    accept;
	result_t res_d;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel_mode  <= 1'b0;
			cfg_q.disp_width  <= DIM_BITS'(RESET_WIDTH);
			cfg_q.disp_height <= DIM_BITS'(RESET_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WHEEL_MODE:  cfg_q.wheel_mode  <= cfg_data[0];
				CFG_DISP_WIDTH:  cfg_q.disp_width  <= cfg_data[DIM_BITS-1:0];
				CFG_DISP_HEIGHT: cfg_q.disp_height <= cfg_data[DIM_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign fire     = valid_s1 && out_ready;
	assign in_stall = valid_s1 && !out_ready;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.req_type    <= req_type;
			item_s1.buffer_full <= buffer_full;
			item_s1.from_aux    <= from_aux;
			item_s1.data_byte   <= data_byte;
		end
	end

	ps2mpt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.fire   (fire),
		.item   (item_s1),
		.res    (res_d)
	);

	ps2mpt_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire),
		.res_in  (res_d),
		.ready   (out_ready),
		.valid   (out_valid),
		.stall   (out_stall),
		.res_out (res_q)
	);

	assign packet_done = res_q.packet_done;
	assign cursor_x    = res_q.cursor_x;
	assign cursor_y    = res_q.cursor_y;
	assign wheel_pos   = res_q.wheel_pos;
	assign btn_left    = res_q.buttons[0];
	assign btn_right   = res_q.buttons[1];
	assign btn_middle  = res_q.buttons[2];

endmodule

// ===== test/ps2_mouse_packet_tracker_checker.sv =====
// ----------------------------------------------------------------------------
// ps2 mouse packet tracker checker
// watches the configuration port and both channels, keeps its own copy of the
// packet, cursor and wheel state, and compares every result with a prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker_checker import ps2mpt_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [CFG_BITS-1:0]          cfg_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         req_type,
	input  logic                         buffer_full,
	input  logic                         from_aux,
	input  logic [7:0]                   data_byte,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic                         packet_done,
	input  logic [COORD_BITS-1:0]        cursor_x,
	input  logic [COORD_BITS-1:0]        cursor_y,
	input  logic signed [WHEEL_BITS-1:0] wheel_pos,
	input  logic                         btn_left,
	input  logic                         btn_right,
	input  logic                         btn_middle,
	output int                           pending,
	output int                           mismatch_count,
	output int                           reports_checked,
	output int                           packets_seen,
	output int                           wheel_low,
	output int                           wheel_high
);

	localparam int SPAN_MAX   = 1 << COORD_BITS;
	localparam int WHEEL_TOP  = (1 << (WHEEL_BITS - 1)) - 1;
	localparam int WHEEL_FLOOR = -(1 << (WHEEL_BITS - 1));

	logic                wheel_on;
	logic [CFG_BITS-1:0] width_cfg;
	logic [CFG_BITS-1:0] height_cfg;

	int unsigned bytes_held;
	logic [7:0]  held_byte [3];
	int          x_pos;
	int          y_pos;
	int          z_pos;
	logic [2:0]  btn_state;

	result_t reports_due [$];
	result_t due;
	item_t   incoming;

	// zero acts as one pixel, anything past the coordinate range as the full range
	function automatic int screen_span(input logic [CFG_BITS-1:0] v);
		if (v == '0) return 1;
		if (int'(v) > SPAN_MAX) return SPAN_MAX;
		return int'(v);
	endfunction

	function automatic int clamp_coord(input int p, input int span);
		if (p < 0) p = 0;
		if (p >= span) p = span - 1;
		return p;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	task automatic track_item(input item_t it, output result_t r);
		int unsigned last;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		int          dx;
		int          dy;
		int          z;
		r.packet_done = 1'b0;
		if (it.req_type == REQ_RECENTER) begin
			x_pos = screen_span(width_cfg) / 2;
			y_pos = screen_span(height_cfg) / 2;
			z_pos = 0;
			bytes_held = 0;
		end else if (it.buffer_full && it.from_aux) begin
			last = wheel_on ? 3 : 2;
			// three bytes left over after wheel mode was turned off
			if (bytes_held > last) bytes_held = 0;
			if (bytes_held != 0 || it.data_byte[SYNC_BIT]) begin
				if (bytes_held < last) begin
					held_byte[bytes_held] = it.data_byte;
					bytes_held++;
				end else begin
					b0 = held_byte[0];
					b1 = held_byte[1];
					b2 = wheel_on ? held_byte[2] : it.data_byte;
					bytes_held = 0;
					btn_state = b0[2:0];
					// bits 4 and 5 of the header are the ninth bits of dx and dy
					dx = int'(b1) - (b0[4] ? 256 : 0);
					dy = int'(b2) - (b0[5] ? 256 : 0);
					x_pos = clamp_coord(x_pos + dx, screen_span(width_cfg));
					y_pos = clamp_coord(y_pos - dy, screen_span(height_cfg));
					if (wheel_on) begin
						z = z_pos + int'($signed(it.data_byte));
						if (z > WHEEL_TOP) z = WHEEL_TOP;
						if (z < WHEEL_FLOOR) z = WHEEL_FLOOR;
						z_pos = z;
					end
					r.packet_done = 1'b1;
				end
			end
		end
		r.cursor_x  = x_pos[COORD_BITS-1:0];
		r.cursor_y  = y_pos[COORD_BITS-1:0];
		r.wheel_pos = z_pos[WHEEL_BITS-1:0];
		r.buttons   = btn_state;
	endtask

	task automatic check_report();
		result_t want;
		if (reports_due.size() == 0) begin
			flag_mismatch("result with no transaction outstanding, cursor_x", cursor_x, 0);
			return;
		end
		want = reports_due.pop_front();
		reports_checked++;
		if (packet_done !== want.packet_done)
			flag_mismatch("packet_done", packet_done, want.packet_done);
		if (cursor_x !== want.cursor_x)
			flag_mismatch("cursor_x", cursor_x, want.cursor_x);
		if (cursor_y !== want.cursor_y)
			flag_mismatch("cursor_y", cursor_y, want.cursor_y);
		if (wheel_pos !== want.wheel_pos)
			flag_mismatch("wheel_pos", $signed(wheel_pos), $signed(want.wheel_pos));
		if (btn_left !== want.buttons[0])
			flag_mismatch("btn_left", btn_left, want.buttons[0]);
		if (btn_right !== want.buttons[1])
			flag_mismatch("btn_right", btn_right, want.buttons[1]);
		if (btn_middle !== want.buttons[2])
			flag_mismatch("btn_middle", btn_middle, want.buttons[2]);
		if (want.packet_done) packets_seen++;
		if ($signed(want.wheel_pos) < wheel_low) wheel_low = $signed(want.wheel_pos);
		if ($signed(want.wheel_pos) > wheel_high) wheel_high = $signed(want.wheel_pos);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_on = 1'b0;
			width_cfg = CFG_BITS'(RESET_WIDTH);
			height_cfg = CFG_BITS'(RESET_HEIGHT);
			bytes_held = 0;
			x_pos = RESET_WIDTH / 2;
			y_pos = RESET_HEIGHT / 2;
			z_pos = 0;
			btn_state = '0;
			reports_due.delete();
			pending = 0;
		end else begin
			// results come out registered, so compare before taking this edge's transaction
			if (out_valid && !out_stall) check_report();
			if (cfg_we) begin
				case (cfg_index)
					CFG_WHEEL_MODE: begin
						wheel_on = cfg_data[0];
					end
					CFG_DISP_WIDTH: begin
						width_cfg = cfg_data;
					end
					CFG_DISP_HEIGHT: begin
						height_cfg = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				incoming = {req_type, buffer_full, from_aux, data_byte};
				track_item(incoming, due);
				reports_due.push_back(due);
			end
			pending = reports_due.size();
		end
	end

endmodule

// ===== test/ps2_mouse_packet_tracker_test.sv =====
// ----------------------------------------------------------------------------
// ps2 mouse packet tracker testbench
// directed packets and special cases, then random packet streams with noise
// under several screen and wheel settings, with random stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker_test;

	import ps2mpt_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD   = 400;
	localparam int TREND_COUNT = 280;
	localparam int TREND_DOWN  = 40;
	localparam int PHASE_PKTS  = 30;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [1:0]                   cfg_index = CFG_WHEEL_MODE;
	logic [CFG_BITS-1:0]          cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         req_type = REQ_BYTE;
	logic                         buffer_full = 1'b0;
	logic                         from_aux = 1'b0;
	logic [7:0]                   data_byte = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b1;
	logic                         packet_done;
	logic [COORD_BITS-1:0]        cursor_x;
	logic [COORD_BITS-1:0]        cursor_y;
	logic signed [WHEEL_BITS-1:0] wheel_pos;
	logic                         btn_left;
	logic                         btn_right;
	logic                         btn_middle;

	int pending;
	int mismatch_count;
	int reports_checked;
	int packets_seen;
	int wheel_low;
	int wheel_high;

	bit no_idle = 1'b0;
	bit hold_request = 1'b0;
	bit wheel_now = 1'b0;
	int items_offered = 0;
	int cycle_count = 0;

	ps2_mouse_packet_tracker u_dut (.*);

	ps2_mouse_packet_tracker_checker u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random stall before each result, one long hold on request
	initial begin
		int w;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			w = no_idle ? 0 : $urandom_range(0, 17);
			if (hold_request) begin
				hold_request = 1'b0;
				w = LONG_HOLD;
			end
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	task automatic offer(input item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		{req_type, buffer_full, from_aux, data_byte} <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		items_offered++;
		if ($urandom_range(0, 63) == 0) no_idle = ($urandom_range(0, 2) == 0);
	endtask

	task automatic offer_recenter();
		item_t it;
		it.req_type = REQ_RECENTER;
		{it.buffer_full, it.from_aux, it.data_byte} = 10'($urandom);
		offer(it);
	endtask

	// noise level 1 slips in unflagged bytes, level 2 also recenters and breaks packets
	task automatic offer_byte(input logic [7:0] b, input int noise);
		item_t it;
		if (noise > 0 && $urandom_range(0, 15) == 0) begin
			it.req_type = REQ_BYTE;
			it.data_byte = 8'($urandom);
			{it.buffer_full, it.from_aux} = 2'($urandom_range(0, 2));
			offer(it);
		end
		offer({REQ_BYTE, 1'b1, 1'b1, b});
	endtask

	task automatic offer_packet(input int trend, input int noise);
		logic [7:0] seq [4];
		int         n;
		int         k;
		seq[0] = 8'($urandom);
		seq[0][SYNC_BIT] = 1'b1;
		seq[1] = 8'($urandom);
		seq[2] = 8'($urandom);
		seq[3] = 8'($urandom);
		if (trend > 0) begin
			seq[0][5:4] = 2'b00;
			seq[1] = 8'($urandom_range(160, 255));
			seq[2] = 8'($urandom_range(160, 255));
			if ($urandom_range(0, 31) != 0) seq[3] = 8'h7f;
		end else if (trend < 0) begin
			seq[0][5:4] = 2'b11;
			seq[1] = 8'($urandom_range(0, 95));
			seq[2] = 8'($urandom_range(0, 95));
			if ($urandom_range(0, 31) != 0) seq[3] = 8'h80;
		end
		n = wheel_now ? 4 : 3;
		if (noise > 1) begin
			// stray byte without the sync bit ahead of the header
			if ($urandom_range(0, 15) == 0) offer_byte(8'($urandom) & 8'hf7, 0);
			if ($urandom_range(0, 31) == 0) offer_recenter();
			if ($urandom_range(0, 19) == 0) n = $urandom_range(1, n - 1);
		end
		for (k = 0; k < n; k++) begin
			if (noise > 1 && k > 0 && $urandom_range(0, 47) == 0) offer_recenter();
			offer_byte(seq[k], noise);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_BITS'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input bit wheel, input int width, input int height);
		settle();
		write_reg(CFG_WHEEL_MODE, int'(wheel));
		write_reg(CFG_DISP_WIDTH, width);
		write_reg(CFG_DISP_HEIGHT, height);
		wheel_now = wheel;
	endtask

	function automatic int random_dim();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return $urandom_range(2, 16);
			3: return $urandom_range(17, 4095);
			4: return 4096;
			default: return $urandom_range(4097, 8191);
		endcase
	endfunction

	task automatic random_phase(input int packets);
		configure(1'($urandom_range(0, 1)), random_dim(), random_dim());
		if ($urandom_range(0, 1)) offer_recenter();
		repeat (packets) offer_packet(0, 2);
	endtask

	initial begin
		int k;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: dropped bytes, resync, extreme deltas, recenter
		offer({REQ_BYTE, 1'b0, 1'b1, 8'h08});
		offer({REQ_BYTE, 1'b1, 1'b0, 8'hff});
		offer({REQ_BYTE, 1'b1, 1'b1, 8'h00});
		offer_byte(8'hff, 0);
		offer_byte(8'h00, 0);
		offer_byte(8'h00, 0);
		offer_byte(8'h08, 0);
		offer_byte(8'hff, 0);
		offer_byte(8'hff, 0);
		offer({REQ_RECENTER, 1'b0, 1'b0, 8'h00});

		// wheel packets on a degenerate width and an oversized height
		configure(1'b1, 0, 8191);
		offer({REQ_RECENTER, 1'b1, 1'b1, 8'hff});
		offer_byte(8'h09, 0);
		offer_byte(8'h10, 0);
		offer_byte(8'h20, 0);
		offer_byte(8'h7f, 0);
		offer_byte(8'h38, 0);
		offer_byte(8'h80, 0);
		offer_byte(8'h80, 0);
		offer_byte(8'h80, 0);

		// three bytes held when wheel mode goes off: the next byte starts over
		offer_byte(8'h0a, 0);
		offer_byte(8'h01, 0);
		offer_byte(8'h02, 0);
		configure(1'b0, 4096, 1);
		offer_byte(8'h0b, 0);
		offer_byte(8'h05, 0);
		offer_byte(8'h06, 0);

		random_phase(PHASE_PKTS);

		// drive the wheel and cursor to the top, holding results off for a while
		configure(1'b1, 8191, 4096);
		offer_recenter();
		for (k = 0; k < TREND_COUNT; k++) begin
			if (k == 40) hold_request = 1'b1;
			offer_packet(1, 1);
		end

		configure(1'b1, 4096, 8191);
		offer_recenter();
		for (k = 0; k < TREND_DOWN; k++) offer_packet(-1, 1);

		random_phase(PHASE_PKTS);

		settle();
		repeat (8) @(negedge clk);
		$display("%0d transactions offered, %0d results checked, %0d complete packets",
			items_offered, reports_checked, packets_seen);
		$display("wheel position ranged %0d to %0d over wheel and byte-only screen settings",
			wheel_low, wheel_high);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ps2mpt_pkg.sv
rtl/ps2mpt_core.sv
rtl/ps2mpt_out_reg.sv
rtl/ps2_mouse_packet_tracker.sv
test/ps2_mouse_packet_tracker_checker.sv
test/ps2_mouse_packet_tracker_test.sv
